FILE: hw/rtl/mrx_pkg.sv
// Package: shared types and constants for the Manchester line receiver.
package mrx_pkg;

    // Width of the sample delay register and its reset value
    localparam int unsigned CFG_WIDTH          = 16;
    localparam logic [15:0] SAMPLE_DELAY_RESET = 16'd68;

    // Delay counter width default
    localparam int unsigned DELAY_WIDTH_DEFAULT = 16;

    // Byte framing: a second start edge after the half byte, emit after a full byte
    localparam logic [3:0] HALF_BYTE_BITS = 4'd4;
    localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

    // Receiver phase
    typedef enum logic [1:0] {
        PH_WAIT_A    = 2'd0,
        PH_WAIT_B    = 2'd1,
        PH_DELAY     = 2'd2,
        PH_WAIT_EDGE = 2'd3
    } t_phase;

    // Result handed from the decoder to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_result;

endpackage

FILE: hw/rtl/mrx_if.sv
// Interfaces: line sample channel and received byte channel.
interface mrx_line_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

interface mrx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] received_byte;

    modport source (output valid, output received_byte, input ready);
    modport sink   (input valid, input received_byte, output ready);
endinterface

FILE: hw/rtl/mrx_decode.sv
// Decoder: edge detection, phase machine, delay counter and bit shifter.
module mrx_decode
    import mrx_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] i_cfg_wr_data,
    input  logic                 i_accept,
    input  logic                 i_level,
    output t_result              o_result
);

    localparam int unsigned EXT_WIDTH = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]   r_sample_delay;
    t_phase                 r_phase, n_phase;
    logic [DELAY_WIDTH-1:0] r_delay_count, n_delay_count;
    logic [3:0]             r_bit_count, n_bit_count;
    logic [7:0]             r_shift_byte, n_shift_byte;
    logic                   r_last_level;

    logic [EXT_WIDTH-1:0]   delay_ext;
    logic [DELAY_WIDTH-1:0] delay_load;
    logic                   edge_seen;
    logic                   fall_seen;
    logic                   delay_done;

    // Fit the configured delay to the counter width
    assign delay_ext  = EXT_WIDTH'(r_sample_delay);
    assign delay_load = delay_ext[DELAY_WIDTH-1:0];

    assign edge_seen  = i_level != r_last_level;
    assign fall_seen  = r_last_level && !i_level;
    assign delay_done = r_delay_count <= DELAY_WIDTH'(1);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_WAIT_A, PH_WAIT_B: begin
                if (fall_seen) n_phase = PH_DELAY;
            end
            PH_DELAY: begin
                if (delay_done) n_phase = PH_WAIT_EDGE;
            end
            PH_WAIT_EDGE: begin
                if (edge_seen) begin
                    priority if (r_bit_count == HALF_BYTE_BITS) n_phase = PH_WAIT_B;
                    else if (r_bit_count == FULL_BYTE_BITS)     n_phase = PH_WAIT_A;
                    else                                        n_phase = PH_DELAY;
                end
            end
            default: n_phase = PH_WAIT_A;
        endcase
    end

    // Datapath and result for the current sample
    always_comb begin
        n_delay_count   = r_delay_count;
        n_bit_count     = r_bit_count;
        n_shift_byte    = r_shift_byte;
        o_result.valid  = 1'b0;
        o_result.data   = r_shift_byte;
        unique case (r_phase)
            PH_WAIT_A: begin
                if (fall_seen) begin
                    n_shift_byte  = 8'd0;
                    n_bit_count   = 4'd0;
                    n_delay_count = delay_load;
                end
            end
            PH_WAIT_B: begin
                if (fall_seen) n_delay_count = delay_load;
            end
            PH_DELAY: begin
                if (delay_done) begin
                    n_delay_count = '0;
                    n_shift_byte  = r_shift_byte | (8'(i_level) << r_bit_count[2:0]);
                    n_bit_count   = r_bit_count + 4'd1;
                end else begin
                    n_delay_count = r_delay_count - DELAY_WIDTH'(1);
                end
            end
            PH_WAIT_EDGE: begin
                if (edge_seen) begin
                    priority if (r_bit_count == HALF_BYTE_BITS) begin
                        n_delay_count = r_delay_count;
                    end else if (r_bit_count == FULL_BYTE_BITS) begin
                        o_result.valid = i_accept;
                    end else begin
                        n_delay_count = delay_load;
                    end
                end
            end
            default: n_delay_count = r_delay_count;
        endcase
    end

    // Hold the delay setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_delay <= SAMPLE_DELAY_RESET;
        end else if (i_cfg_wr_en) begin
            r_sample_delay <= i_cfg_wr_data;
        end
    end

    // Advance state on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT_A;
            r_delay_count <= '0;
            r_bit_count   <= 4'd0;
            r_shift_byte  <= 8'd0;
            r_last_level  <= 1'b1;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_delay_count <= n_delay_count;
            r_bit_count   <= n_bit_count;
            r_shift_byte  <= n_shift_byte;
            r_last_level  <= i_level;
        end
    end

endmodule

FILE: hw/rtl/mrx_out_reg.sv
// Output register: holds one received byte until the consumer takes it.
module mrx_out_reg
    import mrx_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_result            i_result,
    output logic               o_space,
    mrx_byte_if.source         o_byte
);

    logic       r_valid;
    logic [7:0] r_data;

    // Room when empty or when the held byte leaves this cycle
    assign o_space = !r_valid || o_byte.ready;

    assign o_byte.valid         = r_valid;
    assign o_byte.received_byte = r_data;

    // Load a new byte, drop the held one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_result.valid) begin
            r_data <= i_result.data;
        end
    end

endmodule

FILE: hw/rtl/manchester_receiver.sv
// Top level: Manchester line receiver with three-quarter-bit sampling.
//
// Usage:
//   i_rx carries one receive-line level per request (line_level, 1 = high).
//   o_byte carries each completed byte, first received bit in bit zero.
//   i_cfg_wr_en / i_cfg_wr_data write the sample delay in samples, counted
//   from a qualifying edge to the sample that is shifted in (0 acts as 1).
// Throughput: one line sample per cycle while i_rx.ready is high; the decoder
//   updates its phase, delay counter and shift byte in the cycle a sample is accepted.
// Output: a byte appears on o_byte in the cycle after the sample whose edge
//   closes the eighth bit.
// Reset: the decoder waits for a start falling edge, the previous level is
//   taken as high, the sample delay returns to 68 and o_byte is empty.
// Stall: o_byte has a one-byte output register; while it holds a byte that
//   is not taken, i_rx.ready drops and no sample is accepted, so the line
//   source must hold its request.
module manchester_receiver
    import mrx_pkg::*;
#(
    parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] i_cfg_wr_data,
    mrx_line_if.sink             i_rx,
    mrx_byte_if.source           o_byte
);

    logic    space;
    logic    accept;
    t_result result;

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    mrx_decode #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_level       (i_rx.line_level),
        .o_result      (result)
    );

    mrx_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_space  (space),
        .o_byte   (o_byte)
    );

endmodule

FILE: tb/manchester_receiver_chk.sv
// Checker: watches the line and byte channels, decodes the line on its own and compares bytes.
module manchester_receiver_chk
    import mrx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_WIDTH-1:0] i_cfg_wr_data,
    input  logic                 i_line_valid,
    input  logic                 i_line_ready,
    input  logic                 i_line_level,
    input  logic                 i_byte_valid,
    input  logic                 i_byte_ready,
    input  logic [7:0]           i_byte_data,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Own copy of the decoder state and the sample delay register
    logic [CFG_WIDTH-1:0] delay_reg;
    t_phase               ph;
    logic [15:0]          delay_left;
    logic [3:0]           bit_cnt;
    logic [7:0]           shift_reg;
    logic                 prev_level;

    logic [7:0] pending_bytes[$];
    int         fail_count = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // Print one line and count it
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Advance the decoder by one line sample; flag a completed byte
    task automatic decode_level(input logic lvl, output logic done, output logic [7:0] value);
        logic is_edge;
        logic is_fall;
        is_edge = (lvl != prev_level);
        is_fall = prev_level && !lvl;
        done    = 1'b0;
        value   = 8'h00;
        case (ph)
            PH_WAIT_A: begin
                if (is_fall) begin
                    shift_reg  = 8'h00;
                    bit_cnt    = 4'd0;
                    delay_left = delay_reg;
                    ph         = PH_DELAY;
                end
            end
            PH_WAIT_B: begin
                if (is_fall) begin
                    delay_left = delay_reg;
                    ph         = PH_DELAY;
                end
            end
            PH_DELAY: begin
                // Zero delay counts as one tick
                if (delay_left <= 16'd1) begin
                    delay_left = 16'd0;
                    shift_reg  = shift_reg | (8'(lvl) << bit_cnt[2:0]);
                    bit_cnt    = bit_cnt + 4'd1;
                    ph         = PH_WAIT_EDGE;
                end else begin
                    delay_left = delay_left - 16'd1;
                end
            end
            default: begin
                if (is_edge) begin
                    if (bit_cnt == HALF_BYTE_BITS) begin
                        ph = PH_WAIT_B;
                    end else if (bit_cnt == FULL_BYTE_BITS) begin
                        done  = 1'b1;
                        value = shift_reg;
                        ph    = PH_WAIT_A;
                    end else begin
                        delay_left = delay_reg;
                        ph         = PH_DELAY;
                    end
                end
            end
        endcase
        prev_level = lvl;
    endtask

    // Predict on each accepted sample, compare each accepted byte with the oldest prediction
    always @(posedge i_clk) begin
        logic       got;
        logic [7:0] val;
        logic [7:0] want;
        if (!i_rst_n) begin
            delay_reg  = SAMPLE_DELAY_RESET;
            ph         = PH_WAIT_A;
            delay_left = 16'd0;
            bit_cnt    = 4'd0;
            shift_reg  = 8'h00;
            prev_level = 1'b1;
            pending_bytes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                delay_reg = i_cfg_wr_data;
            end
            if (i_line_valid && i_line_ready) begin
                decode_level(i_line_level, got, val);
                if (got) begin
                    pending_bytes.push_back(val);
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with none expected", i_byte_data));
                end else begin
                    want = pending_bytes.pop_front();
                    if (i_byte_data !== want) begin
                        report_mismatch($sformatf("received_byte %02h, expected %02h",
                                                  i_byte_data, want));
                    end
                end
            end
        end
        o_pending    <= pending_bytes.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: tb/manchester_receiver_tb.sv
// Testbench top: drives Manchester frames into the receiver, stalls the byte side, gives the verdict.
module manchester_receiver_tb;
    import mrx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_WIDTH-1:0] cfg_wr_data;

    mrx_line_if rx_ch ();
    mrx_byte_if byte_ch ();

    int pending;
    int fail_count;
    int cycles     = 0;
    int line_items = 0;
    int eff_delay  = 68;
    logic line_now = 1'b1;
    logic calm     = 1'b0;
    logic hold_req = 1'b0;

    manchester_receiver DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_rx          (rx_ch),
        .o_byte        (byte_ch)
    );

    manchester_receiver_chk u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_line_valid  (rx_ch.valid),
        .i_line_ready  (rx_ch.ready),
        .i_line_level  (rx_ch.line_level),
        .i_byte_valid  (byte_ch.valid),
        .i_byte_ready  (byte_ch.ready),
        .i_byte_data   (byte_ch.received_byte),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles; stop a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[manchester_receiver] ERROR");
            $finish;
        end
    end

    // Byte side: random stalls, one long hold-off, and no stalls while calm
    initial begin
        int hold_left;
        logic hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        byte_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                byte_ch.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
                byte_ch.ready <= 1'b0;
            end else begin
                byte_ch.ready <= calm || ($urandom_range(99, 0) >= 7);
            end
        end
    end

    // Offer one line sample, with an occasional gap, and hold it until accepted
    task automatic send_level(input logic lvl);
        if (!calm && $urandom_range(99, 0) < 7) begin
            repeat ($urandom_range(3, 1)) begin
                @(negedge clk);
                rx_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        rx_ch.valid      <= 1'b1;
        rx_ch.line_level <= lvl;
        do @(posedge clk); while (!rx_ch.ready);
        line_now = lvl;
        line_items++;
    endtask

    // Drop the request and wait until every predicted byte is out
    task automatic settle();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the sample delay register
    task automatic write_delay(input logic [CFG_WIDTH-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        eff_delay = (value == '0) ? 1 : int'(value);
    endtask

    // Send a frame: start fall, nbits Manchester bits, second start fall after the half byte.
    // Each bit: optional boundary toggle before the sample point, sample, then the closing edge.
    task automatic send_frame(input logic [7:0] data, input int nbits);
        int h;
        int e;
        logic b;
        repeat ($urandom_range(4, 1)) send_level(1'b1);
        send_level(1'b0);
        for (int i = 0; i < nbits; i++) begin
            if (i == 4) begin
                repeat ($urandom_range(2, 0)) send_level(line_now);
                if (!line_now) begin
                    repeat ($urandom_range(2, 1)) send_level(1'b1);
                end
                send_level(1'b0);
            end
            b = data[i];
            h = $urandom_range(eff_delay, (eff_delay + 1) / 2);
            e = eff_delay + 1 + $urandom_range(eff_delay / 2 + 2, 0);
            for (int t = 1; t <= e; t++) begin
                if (t == e) begin
                    send_level(~b);
                end else if (t >= h) begin
                    send_level(b);
                end else begin
                    send_level(line_now);
                end
            end
        end
    endtask

    // Stimulus
    initial begin
        int rand_base;
        int frames_since_cfg;
        int pick;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        rx_ch.valid      = 1'b0;
        rx_ch.line_level = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset delay, then the shortest delay with all-zero and all-one bytes
        send_frame(8'hA5, 8);
        settle();
        write_delay(16'd1);
        send_frame(8'h00, 8);
        send_frame(8'hFF, 8);

        // Zero delay acts as one tick
        settle();
        write_delay(16'd0);
        send_frame(8'($urandom_range(255, 0)), 8);
        settle();
        write_delay(16'd3);

        // Random part: mostly frames with random content, some noise and cut-off frames
        rand_base        = line_items;
        frames_since_cfg = 0;
        while ((line_items - rand_base) < 1000) begin
            if (frames_since_cfg >= 5) begin
                settle();
                pick = $urandom_range(99, 0);
                if (pick < 60) begin
                    write_delay(CFG_WIDTH'($urandom_range(10, 1)));
                end else if (pick < 80) begin
                    write_delay(CFG_WIDTH'($urandom_range(40, 11)));
                end else if (pick < 90) begin
                    write_delay(16'd0);
                end else begin
                    write_delay(16'd1);
                end
                frames_since_cfg = 0;
            end
            pick = $urandom_range(99, 0);
            if (pick < 82) begin
                send_frame(8'($urandom_range(255, 0)), 8);
            end else if (pick < 92) begin
                repeat ($urandom_range(16, 1)) send_level(1'($urandom_range(1, 0)));
            end else begin
                send_frame(8'($urandom_range(255, 0)), $urandom_range(7, 1));
            end
            frames_since_cfg++;
            hold_req = ((line_items - rand_base) >= 200);
            calm     = ((line_items - rand_base) >= 500) && ((line_items - rand_base) < 800);
        end
        calm = 1'b0;

        // Drain and give the verdict
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("[manchester_receiver] OK");
        end else begin
            $display("[manchester_receiver] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/mrx_pkg.sv
hw/rtl/mrx_if.sv
hw/rtl/mrx_decode.sv
hw/rtl/mrx_out_reg.sv
hw/rtl/manchester_receiver.sv
tb/manchester_receiver_chk.sv
tb/manchester_receiver_tb.sv
